[rtl/tlru_pkg.sv]
package tlru_pkg;

    localparam int ENTRIES      = 256;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int CNT_W        = $clog2(ENTRIES + 1);
    localparam int PAYLOAD_BITS = 32;
    localparam int STAMP_BITS   = 32;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_MOVE   = 2'd2;
    localparam logic [1:0] CMD_PEEK   = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_NO_USE = 2'd3;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [IDX_W-1:0]        node_index;
        logic [PAYLOAD_BITS-1:0] payload_in;
        logic [STAMP_BITS-1:0]   now_time;
    } in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [IDX_W-1:0]        entry_index;
        logic                    head_valid;
        logic [IDX_W-1:0]        head_index;
        logic [PAYLOAD_BITS-1:0] head_payload;
        logic [STAMP_BITS-1:0]   head_stamp;
        logic [CNT_W-1:0]        entry_count;
    } out_t;

    // one link memory port: one write and one read per cycle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } link_port_t;

    // payload and stamp memories share addresses
    typedef struct packed {
        logic                    payload_we;
        logic                    stamp_we;
        logic [IDX_W-1:0]        waddr;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [STAMP_BITS-1:0]   stamp;
        logic                    re;
        logic [IDX_W-1:0]        raddr;
    } data_port_t;

endpackage

[rtl/tlru_ram.sv]
module tlru_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tlru_ctrl.sv]
module tlru_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tlru_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tlru_pkg::out_t                    m_data,
    output tlru_pkg::link_port_t              next_port,
    output tlru_pkg::link_port_t              prev_port,
    output tlru_pkg::data_port_t              data_port,
    input  logic [tlru_pkg::IDX_W-1:0]        next_rdata,
    input  logic [tlru_pkg::IDX_W-1:0]        prev_rdata,
    input  logic [tlru_pkg::PAYLOAD_BITS-1:0] payload_rdata,
    input  logic [tlru_pkg::STAMP_BITS-1:0]   stamp_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_MOVE2 = 5'b00100,
        ST_HEAD  = 5'b01000,
        ST_LOAD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    tlru_pkg::in_t  item_reg, item_next;
    tlru_pkg::out_t m_data_reg, m_data_next;
    logic           m_valid_reg, m_valid_next;

    logic [1:0]                 status_reg, status_next;
    logic [tlru_pkg::IDX_W-1:0] entry_reg, entry_next;

    logic [tlru_pkg::IDX_W-1:0] head_reg, head_next;
    logic [tlru_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [tlru_pkg::IDX_W-1:0] free_head_reg, free_head_next;
    logic [tlru_pkg::CNT_W-1:0] used_reg, used_next;
    logic [tlru_pkg::CNT_W-1:0] free_count_reg, free_count_next;
    logic [tlru_pkg::CNT_W-1:0] fresh_reg, fresh_next;
    logic [tlru_pkg::ENTRIES-1:0] in_use_reg, in_use_next;

    logic                       use_free;
    logic [tlru_pkg::IDX_W-1:0] alloc_idx;
    logic [tlru_pkg::IDX_W-1:0] node;

    assign use_free  = (free_count_reg != '0);
    assign alloc_idx = use_free ? free_head_reg : fresh_reg[tlru_pkg::IDX_W-1:0];
    assign node      = item_reg.node_index;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;
        status_next     = status_reg;
        entry_next      = entry_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        used_next       = used_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        in_use_next     = in_use_reg;
        next_port       = '0;
        prev_port       = '0;
        data_port       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    // fetch the link word the command will need
                    next_port.re = 1'b1;
                    case (s_data.cmd)
                        tlru_pkg::CMD_DELETE: next_port.raddr = head_reg;
                        tlru_pkg::CMD_MOVE:   next_port.raddr = s_data.node_index;
                        default:              next_port.raddr = free_head_reg;
                    endcase
                    prev_port.re    = 1'b1;
                    prev_port.raddr = s_data.node_index;
                    state_next      = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next  = ST_HEAD;
                status_next = tlru_pkg::STATUS_OK;
                entry_next  = '0;
                case (item_reg.cmd)
                    tlru_pkg::CMD_APPEND: begin
                        if (used_reg == tlru_pkg::CNT_W'(tlru_pkg::ENTRIES)) begin
                            status_next = tlru_pkg::STATUS_FULL;
                        end else begin
                            if (use_free) begin
                                free_head_next  = next_rdata;
                                free_count_next = free_count_reg - 1'b1;
                            end else begin
                                fresh_next = fresh_reg + 1'b1;
                            end
                            data_port.payload_we = 1'b1;
                            data_port.stamp_we   = 1'b1;
                            data_port.waddr      = alloc_idx;
                            data_port.payload    = item_reg.payload_in;
                            data_port.stamp      = item_reg.now_time;
                            in_use_next[alloc_idx] = 1'b1;
                            if (used_reg == '0) begin
                                head_next = alloc_idx;
                            end else begin
                                next_port.we    = 1'b1;
                                next_port.waddr = tail_reg;
                                next_port.wdata = alloc_idx;
                                prev_port.we    = 1'b1;
                                prev_port.waddr = alloc_idx;
                                prev_port.wdata = tail_reg;
                            end
                            tail_next  = alloc_idx;
                            used_next  = used_reg + 1'b1;
                            entry_next = alloc_idx;
                        end
                    end

                    tlru_pkg::CMD_DELETE: begin
                        if (used_reg == '0) begin
                            status_next = tlru_pkg::STATUS_EMPTY;
                        end else begin
                            in_use_next[head_reg] = 1'b0;
                            used_next = used_reg - 1'b1;
                            if (used_reg > tlru_pkg::CNT_W'(1)) begin
                                head_next = next_rdata;
                            end
                            // push the old head onto the free stack
                            next_port.we    = 1'b1;
                            next_port.waddr = head_reg;
                            next_port.wdata = free_head_reg;
                            free_head_next  = head_reg;
                            free_count_next = free_count_reg + 1'b1;
                            entry_next      = head_reg;
                        end
                    end

                    tlru_pkg::CMD_MOVE: begin
                        entry_next = node;
                        if (!in_use_reg[node]) begin
                            status_next = tlru_pkg::STATUS_NO_USE;
                        end else begin
                            data_port.stamp_we = 1'b1;
                            data_port.waddr    = node;
                            data_port.stamp    = item_reg.now_time;
                            if (node != tail_reg) begin
                                if (node == head_reg) begin
                                    head_next       = next_rdata;
                                    next_port.we    = 1'b1;
                                    next_port.waddr = tail_reg;
                                    next_port.wdata = node;
                                    prev_port.we    = 1'b1;
                                    prev_port.waddr = node;
                                    prev_port.wdata = tail_reg;
                                    tail_next       = node;
                                end else begin
                                    // unlink from the middle, relink at tail next cycle
                                    next_port.we    = 1'b1;
                                    next_port.waddr = prev_rdata;
                                    next_port.wdata = next_rdata;
                                    prev_port.we    = 1'b1;
                                    prev_port.waddr = next_rdata;
                                    prev_port.wdata = prev_rdata;
                                    state_next      = ST_MOVE2;
                                end
                            end
                        end
                    end

                    default: begin
                        if (used_reg == '0) begin
                            status_next = tlru_pkg::STATUS_EMPTY;
                        end else begin
                            entry_next = head_reg;
                        end
                    end
                endcase
            end

            ST_MOVE2: begin
                next_port.we    = 1'b1;
                next_port.waddr = tail_reg;
                next_port.wdata = node;
                prev_port.we    = 1'b1;
                prev_port.waddr = node;
                prev_port.wdata = tail_reg;
                tail_next       = node;
                state_next      = ST_HEAD;
            end

            ST_HEAD: begin
                data_port.re    = 1'b1;
                data_port.raddr = head_reg;
                state_next      = ST_LOAD;
            end

            ST_LOAD: begin
                // hold the head read data until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.entry_index  = entry_reg;
                    m_data_next.entry_count  = used_reg;
                    if (used_reg != '0) begin
                        m_data_next.head_valid   = 1'b1;
                        m_data_next.head_index   = head_reg;
                        m_data_next.head_payload = payload_rdata;
                        m_data_next.head_stamp   = stamp_rdata;
                    end else begin
                        m_data_next.head_valid   = 1'b0;
                        m_data_next.head_index   = '0;
                        m_data_next.head_payload = '0;
                        m_data_next.head_stamp   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_head_reg  <= '0;
            used_reg       <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            in_use_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_head_reg  <= free_head_next;
            used_reg       <= used_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            in_use_reg     <= in_use_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
    end

endmodule

[rtl/timestamped_lru_list.sv]
// Each command steps through a link read, the list update, a head payload/stamp read and
// a result load; a move of an entry from the middle of the list adds a link write step
// before the head read. s_ready is high only in idle, so no new command is taken until
// the last one has loaded its result; a result waiting on m_ready holds the next load.
// Reset (aresetn low, synchronous) empties the list and drops any pending result;
// link, payload and stamp memories keep their contents and need no clearing pass.
module timestamped_lru_list (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tlru_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tlru_pkg::out_t m_data
);

    tlru_pkg::link_port_t next_port;
    tlru_pkg::link_port_t prev_port;
    tlru_pkg::data_port_t data_port;

    logic [tlru_pkg::IDX_W-1:0]        next_rdata;
    logic [tlru_pkg::IDX_W-1:0]        prev_rdata;
    logic [tlru_pkg::PAYLOAD_BITS-1:0] payload_rdata;
    logic [tlru_pkg::STAMP_BITS-1:0]   stamp_rdata;

    tlru_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .next_port     (next_port),
        .prev_port     (prev_port),
        .data_port     (data_port),
        .next_rdata    (next_rdata),
        .prev_rdata    (prev_rdata),
        .payload_rdata (payload_rdata),
        .stamp_rdata   (stamp_rdata)
    );

    tlru_ram #(.DEPTH(tlru_pkg::ENTRIES), .WIDTH(tlru_pkg::IDX_W)) u_next_ram (
        .aclk  (aclk),
        .we    (next_port.we),
        .waddr (next_port.waddr),
        .wdata (next_port.wdata),
        .re    (next_port.re),
        .raddr (next_port.raddr),
        .rdata (next_rdata)
    );

    tlru_ram #(.DEPTH(tlru_pkg::ENTRIES), .WIDTH(tlru_pkg::IDX_W)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_port.we),
        .waddr (prev_port.waddr),
        .wdata (prev_port.wdata),
        .re    (prev_port.re),
        .raddr (prev_port.raddr),
        .rdata (prev_rdata)
    );

    tlru_ram #(.DEPTH(tlru_pkg::ENTRIES), .WIDTH(tlru_pkg::PAYLOAD_BITS)) u_payload_ram (
        .aclk  (aclk),
        .we    (data_port.payload_we),
        .waddr (data_port.waddr),
        .wdata (data_port.payload),
        .re    (data_port.re),
        .raddr (data_port.raddr),
        .rdata (payload_rdata)
    );

    tlru_ram #(.DEPTH(tlru_pkg::ENTRIES), .WIDTH(tlru_pkg::STAMP_BITS)) u_stamp_ram (
        .aclk  (aclk),
        .we    (data_port.stamp_we),
        .waddr (data_port.waddr),
        .wdata (data_port.stamp),
        .re    (data_port.re),
        .raddr (data_port.raddr),
        .rdata (stamp_rdata)
    );

endmodule

[rtl/tlru_checker.sv]
module tlru_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input tlru_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input tlru_pkg::out_t m_data
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // the input side must also hold while stalled
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("command beat changed while stalled");

    a_head_vs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.head_valid == (m_data.entry_count != '0))
        else $error("head_valid disagrees with entry_count");

    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.head_valid |-> m_data.head_index == '0 &&
            m_data.head_payload == '0 && m_data.head_stamp == '0)
        else $error("empty list reports a head");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= tlru_pkg::CNT_W'(tlru_pkg::ENTRIES))
        else $error("entry_count beyond capacity");

endmodule

bind timestamped_lru_list tlru_checker u_tlru_checker (.*);
